FILE: rtl/llpm_pkg.sv
package llpm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 3;

  localparam logic [LEN_W-1:0]  MAX_PREFIX_LEN = LEN_W'(ADDR_W);
  localparam logic [ADDR_W-1:0] ALL_ONES       = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_FOUND   = 3'd2,
    ST_NOROUTE = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] lookup_addr;
    logic [ADDR_W-1:0] route_prefix;
    logic [LEN_W-1:0]  prefix_len;
    logic [ADDR_W-1:0] hop_addr;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] next_hop;
  } out_res_t;

  // one route entry as held in a cell
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] hop;
  } entry_t;

  // table control broadcast to every cell
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] entry_count;
  } tbl_ctl_t;

  // search request walking down the chain
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] hop;
  } token_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    // len is at most 32: length 0 gives an empty mask, 32 a full one
    prefix_mask = ~(ALL_ONES >> len);
  endfunction

endpackage

FILE: rtl/linear_longest_prefix_match_unit.sv
// channel  ports                          payload
// in       in_valid / in_stall            in_req   (func, addrs, prefix_len, hop)
// out      out_valid / out_stall          out_res  (status, next_hop)
//
// Append, clear and unused codes answer in the cycle after the request is taken.
// A lookup walks the cell chain one cell per cycle, with one request in flight.
// Reset empties the table (entry count to zero); no clearing pass.
// out_stall holds the result register; in_stall is high while a lookup runs
// or a result waits that cannot leave this cycle.
module linear_longest_prefix_match_unit import llpm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  state_t   state_r, state_nxt;
  logic     out_valid_r, out_valid_nxt;
  out_res_t out_res_r, out_res_nxt;
  out_res_t hold_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic     out_free;
  logic     in_acc;
  logic     wr_en;
  tbl_ctl_t tbl_ctl;
  entry_t   wr_entry;
  logic     head_vld;
  token_t   head_tok;

  logic   tok_vld [0:TABLE_DEPTH];
  token_t tok     [0:TABLE_DEPTH];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_req.func == FN_LOOKUP)) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (tok_vld[TABLE_DEPTH]) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and table control
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    head_vld      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_res_nxt.next_hop = ALL_ONES;
          case (in_req.func)
            FN_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                out_res_nxt.status = ST_FULL;
              end else begin
                out_res_nxt.status = ST_STORED;
                wr_en              = 1'b1;
                count_nxt          = count_r + 1'b1;
              end
            end
            FN_LOOKUP: begin
              head_vld = 1'b1;
            end
            FN_CLEAR: begin
              out_valid_nxt      = 1'b1;
              out_res_nxt.status = ST_CLEARED;
              count_nxt          = '0;
            end
            default: begin
              out_valid_nxt      = 1'b1;
              out_res_nxt.status = ST_NOROUTE;
            end
          endcase
        end
      end
      S_SEARCH: begin
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = hold_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (tok_vld[TABLE_DEPTH]) begin
      hold_r.status   <= tok[TABLE_DEPTH].found ? ST_FOUND : ST_NOROUTE;
      hold_r.next_hop <= tok[TABLE_DEPTH].found ? tok[TABLE_DEPTH].hop : ALL_ONES;
    end
  end

  assign wr_entry.prefix = in_req.route_prefix;
  assign wr_entry.len    = (in_req.prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                                : in_req.prefix_len;
  assign wr_entry.hop    = in_req.hop_addr;

  assign tbl_ctl.wr_en       = wr_en;
  assign tbl_ctl.wr_idx      = count_r[IDX_W-1:0];
  assign tbl_ctl.entry_count = count_r;

  assign head_tok.found = 1'b0;
  assign head_tok.addr  = in_req.lookup_addr;
  assign head_tok.hop   = ALL_ONES;

  assign tok_vld[0] = head_vld;
  assign tok[0]     = head_tok;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    llpm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (IDX_W'(i)),
      .tbl_ctl     (tbl_ctl),
      .wr_entry    (wr_entry),
      .tok_vld_in  (tok_vld[i]),
      .tok_in      (tok[i]),
      .tok_vld_out (tok_vld[i+1]),
      .tok_out     (tok[i+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: rtl/llpm_cell.sv
module llpm_cell import llpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  tbl_ctl_t         tbl_ctl,
  input  entry_t           wr_entry,
  input  logic             tok_vld_in,
  input  token_t           tok_in,
  output logic             tok_vld_out,
  output token_t           tok_out
);

  entry_t entry_r;
  logic   tok_vld_r;
  token_t tok_r;
  token_t tok_nxt;
  logic   active;
  logic   hit;

  always_ff @(posedge clk) begin
    if (tbl_ctl.wr_en && (tbl_ctl.wr_idx == cell_idx)) begin
      entry_r <= wr_entry;
    end
  end

  assign active = CNT_W'(cell_idx) < tbl_ctl.entry_count;
  assign hit    = active &&
                  (((entry_r.prefix ^ tok_in.addr) & prefix_mask(entry_r.len)) == '0);

  always_comb begin
    tok_nxt = tok_in;
    // first hit wins; later cells pass the token on untouched
    if (!tok_in.found && hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.hop   = entry_r.hop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_vld_out = tok_vld_r;
  assign tok_out     = tok_r;

endmodule

FILE: rtl/llpm_checker.sv
module llpm_sva import llpm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_req,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_res
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // append, clear and unused codes answer on the next cycle
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req.func != FN_LOOKUP) |=> out_valid)
    else $error("non-lookup request did not answer next cycle");

  // a running lookup blocks further requests
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req.func == FN_LOOKUP) |=> in_stall && !out_valid)
    else $error("request taken during lookup");

  // next hop is all ones unless a route was found
  a_miss_hop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status != ST_FOUND) |-> out_res.next_hop == ALL_ONES)
    else $error("next hop not all ones without a route");

endmodule

bind linear_longest_prefix_match_unit llpm_sva u_llpm_sva (.*);

FILE: dv/llpm_checker.sv
`timescale 1ns / 1ps

module llpm_checker import llpm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_res_t out_res,
  output int       fail_count,
  output int       pending
);

  logic [ADDR_W-1:0] route_prefix_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]  route_len_mem    [TABLE_DEPTH];
  logic [ADDR_W-1:0] route_hop_mem    [TABLE_DEPTH];
  int                route_count;
  out_res_t          answer_q[$];

  function automatic logic [ADDR_W-1:0] len_mask(logic [LEN_W-1:0] len);
    // shift by the full width yields zero, so length 0 matches everything
    return ALL_ONES << (ADDR_W - int'(len));
  endfunction

  // applies one request to the route table and returns its answer
  function automatic out_res_t serve_request(in_req_t req);
    out_res_t          ans;
    logic [ADDR_W-1:0] m;
    logic [LEN_W-1:0]  len;
    ans.status   = ST_NOROUTE;
    ans.next_hop = ALL_ONES;
    case (req.func)
      FN_APPEND: begin
        if (route_count >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          len = (req.prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : req.prefix_len;
          route_prefix_mem[route_count] = req.route_prefix;
          route_len_mem[route_count]    = len;
          route_hop_mem[route_count]    = req.hop_addr;
          route_count++;
          ans.status = ST_STORED;
        end
      end
      FN_LOOKUP: begin
        for (int i = 0; i < route_count; i++) begin
          m = len_mask(route_len_mem[i]);
          if ((route_prefix_mem[i] & m) == (req.lookup_addr & m)) begin
            ans.status   = ST_FOUND;
            ans.next_hop = route_hop_mem[i];
            break;
          end
        end
      end
      FN_CLEAR: begin
        route_count = 0;
        ans.status  = ST_CLEARED;
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    bit       bad;
    if (!rst_n) begin
      route_count = 0;
      answer_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result, got status %0d next_hop %h",
                   $time, out_res.status, out_res.next_hop);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          bad  = 1'b0;
          if (out_res.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_res.status);
            bad = 1'b1;
          end
          if (out_res.next_hop !== want.next_hop) begin
            $display("%0t: next_hop mismatch, expected %h, got %h",
                     $time, want.next_hop, out_res.next_hop);
            bad = 1'b1;
          end
          if (bad) fail_count <= fail_count + 1;
        end
      end
      if (in_valid && !in_stall) answer_q.push_back(serve_request(in_req));
    end
    pending <= answer_q.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import llpm_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int N_ITEMS      = 1550;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;
  int       fail_count;
  int       pending;

  bit no_idle   = 1'b0;
  bit hold_next = 1'b0;
  int sent      = 0;

  // routes currently in the table, used to aim lookups at real entries
  logic [ADDR_W-1:0] live_prefix[$];
  logic [LEN_W-1:0]  live_len[$];

  always #4 clk = ~clk;

  linear_longest_prefix_match_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  llpm_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_req_t mk_req(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr,
                                     logic [ADDR_W-1:0] pfx, logic [LEN_W-1:0] len,
                                     logic [ADDR_W-1:0] hop);
    in_req_t r;
    r.func         = func;
    r.lookup_addr  = addr;
    r.route_prefix = pfx;
    r.prefix_len   = len;
    r.hop_addr     = hop;
    return r;
  endfunction

  function automatic in_req_t any_req();
    return mk_req(FUNC_W'($urandom_range(0, 3)), $urandom, $urandom,
                  LEN_W'($urandom_range(0, 63)), $urandom);
  endfunction

  function automatic in_req_t append_req(logic [LEN_W-1:0] len);
    return mk_req(FN_APPEND, $urandom, $urandom, len, $urandom);
  endfunction

  function automatic in_req_t lookup_req();
    in_req_t           r;
    int                k;
    int                sat;
    logic [ADDR_W-1:0] m;
    r = mk_req(FN_LOOKUP, $urandom, $urandom, LEN_W'($urandom_range(0, 63)), $urandom);
    if (live_prefix.size() > 0 && $urandom_range(0, 3) != 0) begin
      k   = $urandom_range(0, live_prefix.size() - 1);
      sat = (live_len[k] > MAX_PREFIX_LEN) ? ADDR_W : int'(live_len[k]);
      m   = ALL_ONES << (ADDR_W - sat);
      r.lookup_addr = (live_prefix[k] & m) | (r.lookup_addr & ~m);
      // near miss: flip one bit inside the compared part
      if (sat > 0 && $urandom_range(0, 3) == 0)
        r.lookup_addr[ADDR_W - 1 - $urandom_range(0, sat - 1)] ^= 1'b1;
    end
    return r;
  endfunction

  task automatic offer(in_req_t r);
    int gap;
    bit took;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    sent++;
    if (r.func == FN_APPEND && live_prefix.size() < TABLE_DEPTH) begin
      live_prefix.push_back(r.route_prefix);
      live_len.push_back(r.prefix_len);
    end else if (r.func == FN_CLEAR) begin
      live_prefix.delete();
      live_len.delete();
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : watchdog
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_sink
    int wait_n;
    bit took;
    forever begin
      wait_n = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_next) begin
        hold_next = 1'b0;
        wait_n += LONG_HOLD;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin : stimulus
    int seq;
    int n_app;
    int n_look;
    int cur;
    int step;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unused code, saturating lengths, catch-all route
    offer(mk_req(FN_LOOKUP, '0, '0, '0, '0));
    offer(mk_req(FN_UNUSED, ALL_ONES, ALL_ONES, 6'd63, ALL_ONES));
    offer(mk_req(FN_APPEND, '0, 32'hC0A8_0101, 6'd32, '0));
    offer(mk_req(FN_APPEND, '0, ALL_ONES, 6'd63, ALL_ONES));
    offer(mk_req(FN_APPEND, '0, 32'h0A00_0000, 6'd33, 32'h1111_1111));
    offer(mk_req(FN_APPEND, '0, 32'h8000_0000, 6'd1, 32'h2222_2222));
    offer(mk_req(FN_APPEND, '0, '0, 6'd0, 32'h3333_3333));
    offer(mk_req(FN_LOOKUP, 32'hC0A8_0101, '0, '0, '0));
    offer(mk_req(FN_LOOKUP, 32'hC0A8_0100, '0, '0, '0));
    offer(mk_req(FN_LOOKUP, ALL_ONES, '0, '0, '0));
    offer(mk_req(FN_LOOKUP, 32'h0A00_0000, '0, '0, '0));
    offer(mk_req(FN_LOOKUP, 32'h0A00_0001, '0, '0, '0));
    offer(mk_req(FN_LOOKUP, '0, '0, '0, '0));
    offer(mk_req(FN_UNUSED, '0, '0, '0, '0));
    offer(mk_req(FN_CLEAR, '0, '0, '0, '0));
    offer(mk_req(FN_LOOKUP, ALL_ONES, '0, '0, '0));
    offer(mk_req(FN_APPEND, ALL_ONES, ALL_ONES, 6'd0, 32'h4444_4444));
    offer(mk_req(FN_LOOKUP, 32'h1234_5678, '0, '0, '0));
    offer(mk_req(FN_CLEAR, ALL_ONES, ALL_ONES, 6'd63, ALL_ONES));

    seq = 0;
    while (sent < N_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (seq == 2 || $urandom_range(0, 24) == 0) hold_next = 1'b1;
      if (seq == 4 || $urandom_range(0, 14) == 0) begin
        in_valid <= 1'b0;
        wait_quiet();
      end
      if ($urandom_range(0, 9) < 7) begin
        // well-formed table: clear, appends longest first, then lookups
        offer(mk_req(FN_CLEAR, $urandom, $urandom, LEN_W'($urandom_range(0, 63)), $urandom));
        if (seq == 0)
          n_app = TABLE_DEPTH + 2;
        else if ($urandom_range(0, 6) == 0)
          n_app = $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 4);
        else
          n_app = $urandom_range(1, 16);
        cur = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 63) : ADDR_W;
        for (int k = 0; k < n_app; k++) begin
          offer(append_req(LEN_W'(cur)));
          if (cur > ADDR_W) cur = ADDR_W;
          step = $urandom_range(0, 2);
          cur  = (cur > step) ? cur - step : 0;
          if ($urandom_range(0, 19) == 0) offer(any_req());
        end
        n_look = $urandom_range(3, 12);
        for (int k = 0; k < n_look; k++) offer(lookup_req());
      end else begin
        n_look = $urandom_range(5, 15);
        for (int k = 0; k < n_look; k++)
          offer(($urandom_range(0, 1) == 0) ? lookup_req() : any_req());
      end
      seq++;
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/llpm_pkg.sv
rtl/llpm_cell.sv
rtl/linear_longest_prefix_match_unit.sv
rtl/llpm_checker.sv
dv/llpm_checker.sv
dv/tb.sv
